### rtl/nde_pkg.sv
// Package for the nibble delta sample encoder.
// Field widths, register indexes, queue command type and reset values.
// No dependencies.
package nde_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int LIMIT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DELTA_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL = 2'd1;

  localparam logic [LIMIT_W-1:0]  DELTA_LIMIT_RST      = 3'd7;
  localparam logic [SAMPLE_W-1:0] REFRESH_INTERVAL_RST = 16'd16384;

  localparam logic [NIB_W-1:0]  ESCAPE_NIB  = 4'h8;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h80;

  typedef enum logic [1:0] {
    CMD_PAIR,  // one packed nibble byte
    CMD_ESC,   // escape byte, raw high byte, raw low byte
    CMD_FIN    // terminator byte carrying the checksum
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   first_byte;
    logic [SAMPLE_W-1:0] data;  // raw sample or checksum
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

endpackage

### rtl/nde_if.sv
// Stream interfaces for the nibble delta sample encoder.
// Depends on nde_pkg for field widths.
interface nde_in_if import nde_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface nde_out_if import nde_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_of_run;
  logic                stream_done;
  logic [SAMPLE_W-1:0] checksum;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_done, output checksum, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input stream_done, input checksum, output ready);
endinterface

### rtl/nde_front.sv
// Front end: accepts samples, classifies each delta, keeps the encoder state
// and the configuration registers, and pushes byte commands. Uses nde_pkg.
module nde_front import nde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  q_full,
  output q_push_t               q_push
);

  logic [LIMIT_W-1:0]  delta_limit_r;
  logic [SAMPLE_W-1:0] refresh_interval_r;
  logic [SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic [SAMPLE_W-1:0] running_sum_r, running_sum_nxt;
  logic [SAMPLE_W-1:0] run_count_r, run_count_nxt;
  logic [NIB_W-1:0]    held_nibble_r, held_nibble_nxt;
  logic                pending_r, pending_nxt;

  logic                accept;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W-1:0] mag;
  logic                escape;
  logic [BYTE_W-1:0]   esc_byte;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_limit_r      <= DELTA_LIMIT_RST;
      refresh_interval_r <= REFRESH_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DELTA_LIMIT:      delta_limit_r      <= cfg_wdata[LIMIT_W-1:0];
        REG_REFRESH_INTERVAL: refresh_interval_r <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign diff     = in_sample - prev_sample_r;
  assign mag      = diff[SAMPLE_W-1] ? (~diff + 1'b1) : diff;
  // a minimum-value delta negates to itself and still exceeds any limit
  assign escape   = (mag > {{(SAMPLE_W-LIMIT_W){1'b0}}, delta_limit_r})
                 || (run_count_r >= refresh_interval_r);
  assign esc_byte = pending_r ? {held_nibble_r, ESCAPE_NIB} : ESCAPE_BYTE;

  always_comb begin
    prev_sample_nxt = prev_sample_r;
    running_sum_nxt = running_sum_r;
    run_count_nxt   = run_count_r;
    held_nibble_nxt = held_nibble_r;
    pending_nxt     = pending_r;
    q_push.valid    = 1'b0;
    q_push.cmd      = '{kind: CMD_PAIR, first_byte: esc_byte, data: in_sample};
    if (accept) begin
      if (in_opcode) begin
        q_push.valid    = 1'b1;
        q_push.cmd.kind = CMD_FIN;
        q_push.cmd.data = running_sum_r;
        prev_sample_nxt = '0;
        running_sum_nxt = '0;
        run_count_nxt   = '0;
        held_nibble_nxt = '0;
        pending_nxt     = 1'b0;
      end else begin
        prev_sample_nxt = in_sample;
        running_sum_nxt = running_sum_r + in_sample;
        if (escape) begin
          q_push.valid    = 1'b1;
          q_push.cmd.kind = CMD_ESC;
          run_count_nxt   = '0;
          held_nibble_nxt = '0;
          pending_nxt     = 1'b0;
        end else begin
          run_count_nxt = run_count_r + 1'b1;
          if (pending_r) begin
            q_push.valid          = 1'b1;
            q_push.cmd.kind       = CMD_PAIR;
            q_push.cmd.first_byte = {held_nibble_r, diff[NIB_W-1:0]};
            held_nibble_nxt       = '0;
            pending_nxt           = 1'b0;
          end else begin
            // hold the nibble until its partner arrives
            held_nibble_nxt = diff[NIB_W-1:0];
            pending_nxt     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      running_sum_r <= '0;
      run_count_r   <= '0;
      held_nibble_r <= '0;
      pending_r     <= 1'b0;
    end else begin
      prev_sample_r <= prev_sample_nxt;
      running_sum_r <= running_sum_nxt;
      run_count_r   <= run_count_nxt;
      held_nibble_r <= held_nibble_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

### rtl/nde_queue.sv
// Command queue between front end and back end.
// Small register FIFO of cmd_t entries. Uses nde_pkg.
module nde_queue import nde_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  output logic    pop_valid,
  output cmd_t    pop_cmd,
  input  logic    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
  end

endmodule

### rtl/nde_back.sv
// Back end: expands each queued command into its output bytes, one beat per
// cycle unless the output stalls, through an output register. Uses nde_pkg.
module nde_back import nde_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last,
  output logic                out_done,
  output logic [SAMPLE_W-1:0] out_checksum
);

  logic [1:0]          step_r, step_nxt;
  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic                done_r, done_nxt;
  logic [SAMPLE_W-1:0] sum_r, sum_nxt;
  logic                load;
  logic                final_step;

  assign load = !valid_r || out_ready;

  always_comb begin
    final_step = 1'b1;
    byte_nxt   = q_cmd.first_byte;
    done_nxt   = 1'b0;
    sum_nxt    = '0;
    case (q_cmd.kind)
      CMD_ESC: begin
        case (step_r)
          2'd0:    final_step = 1'b0;
          2'd1: begin
            final_step = 1'b0;
            byte_nxt   = q_cmd.data[SAMPLE_W-1:BYTE_W];
          end
          default: byte_nxt = q_cmd.data[BYTE_W-1:0];
        endcase
      end
      CMD_FIN: begin
        done_nxt = 1'b1;
        sum_nxt  = q_cmd.data;
      end
      default: ;
    endcase
    last_nxt = final_step;
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        if (final_step) begin
          q_pop    = 1'b1;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload holds while a beat is stalled
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_last     = last_r;
  assign out_done     = done_r;
  assign out_checksum = sum_r;

endmodule

### rtl/nibble_delta_sample_encoder_top.sv
// Top level of the nibble delta sample encoder.
// Depends on nde_pkg, nde_if, nde_front, nde_queue, nde_back.
//
//   channel  dir  payload                                      accept
//   in_s     in   opcode, sample                               valid && ready
//   out_m    out  out_byte, last_of_run, stream_done, checksum valid && ready
//   cfg_*    in   cfg_idx, cfg_wdata                           cfg_we
//
// A sample's state update is registered on acceptance; its bytes leave one
// per cycle while out_m is not stalled: one for a packed byte, three for an
// escaped sample, one for a finish. The back end's output register sets the
// sustained rate; new samples enter while earlier bytes leave. Synchronous
// reset clears the state, queue and output valid. in_s.ready drops only when
// the command queue is full; an out_m stall holds the current beat.
module nibble_delta_sample_encoder_top import nde_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nde_in_if.sink                in_s,
  nde_out_if.source             out_m
);

  q_push_t q_push;
  logic    q_full;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_pop;

  nde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .in_opcode (in_s.opcode),
    .in_sample (in_s.sample),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  nde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd),
    .pop       (q_pop)
  );

  nde_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_m.valid),
    .out_ready    (out_m.ready),
    .out_byte     (out_m.out_byte),
    .out_last     (out_m.last_of_run),
    .out_done     (out_m.stream_done),
    .out_checksum (out_m.checksum)
  );

endmodule

### tb/nibble_delta_sample_encoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nibble_delta_sample_encoder_top.
// Drives samples and finish beats into the encoder and checks every output byte.
// Depends on nde_pkg, nde_if and the encoder RTL.
module nibble_delta_sample_encoder_top_tb;
  import nde_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                last_of_run;
    logic                stream_done;
    logic [SAMPLE_W-1:0] checksum;
  } enc_beat_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int IDLE_PCT     = 6;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nde_in_if  in_ch ();
  nde_out_if out_ch ();

  nibble_delta_sample_encoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_ch),
    .out_m     (out_ch)
  );

  // Encoder state as the testbench tracks it
  logic [LIMIT_W-1:0]  enc_limit;
  logic [SAMPLE_W-1:0] enc_refresh;
  logic [SAMPLE_W-1:0] enc_prev;
  logic [SAMPLE_W-1:0] enc_sum;
  logic [SAMPLE_W-1:0] enc_run;
  logic [NIB_W-1:0]    enc_held;
  logic                enc_pend;

  enc_beat_t byte_stream_q[$];

  bit src_idle_on;
  bit sink_stall_on;
  int errors;
  int n_items;
  int n_beats;
  int n_escaped;
  int n_finish;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL nibble_delta_sample_encoder_top");
    $finish;
  end

  function automatic void clear_encoder_state();
    enc_prev = '0;
    enc_sum  = '0;
    enc_run  = '0;
    enc_held = '0;
    enc_pend = 1'b0;
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    input logic done, input logic [SAMPLE_W-1:0] sum);
    enc_beat_t bt;
    bt.out_byte    = b;
    bt.last_of_run = last;
    bt.stream_done = done;
    bt.checksum    = sum;
    byte_stream_q.push_back(bt);
  endfunction

  // Byte carrying the escape nibble; empties the nibble buffer
  function automatic logic [BYTE_W-1:0] take_escape_byte();
    logic [BYTE_W-1:0] b;
    b = enc_pend ? {enc_held, ESCAPE_NIB} : ESCAPE_BYTE;
    enc_held = '0;
    enc_pend = 1'b0;
    return b;
  endfunction

  function automatic void encode_sample(input logic op, input logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W:0]   mag;
    logic [BYTE_W-1:0]   b;
    if (op == OP_FINISH) begin
      b = take_escape_byte();
      push_byte(b, 1'b1, 1'b1, enc_sum);
      n_finish++;
      clear_encoder_state();
      return;
    end
    diff = smp - enc_prev;
    mag  = diff[SAMPLE_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
    if (mag > enc_limit || enc_run >= enc_refresh) begin
      enc_run = '0;
      b = take_escape_byte();
      push_byte(b, 1'b0, 1'b0, '0);
      push_byte(smp[15:8], 1'b0, 1'b0, '0);
      push_byte(smp[7:0], 1'b1, 1'b0, '0);
      n_escaped++;
    end else begin
      enc_run = enc_run + 16'd1;
      if (enc_pend) begin
        push_byte({enc_held, diff[NIB_W-1:0]}, 1'b1, 1'b0, '0);
        enc_held = '0;
        enc_pend = 1'b0;
      end else begin
        enc_held = diff[NIB_W-1:0];
        enc_pend = 1'b1;
      end
    end
    enc_prev = smp;
    enc_sum  = enc_sum + smp;
  endfunction

  // Output side: random backpressure and the byte checker
  initial begin : byte_checker
    enc_beat_t exp_b;
    enc_beat_t got_b;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got_b.out_byte    = out_ch.out_byte;
        got_b.last_of_run = out_ch.last_of_run;
        got_b.stream_done = out_ch.stream_done;
        got_b.checksum    = out_ch.checksum;
        n_beats++;
        if (byte_stream_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat byte=%h last=%b done=%b sum=%h", $time,
                   got_b.out_byte, got_b.last_of_run, got_b.stream_done, got_b.checksum);
        end else begin
          exp_b = byte_stream_q.pop_front();
          if (got_b.out_byte !== exp_b.out_byte || got_b.last_of_run !== exp_b.last_of_run ||
              got_b.stream_done !== exp_b.stream_done || got_b.checksum !== exp_b.checksum) begin
            errors++;
            $display("%0t: mismatch expected byte=%h last=%b done=%b sum=%h", $time,
                     exp_b.out_byte, exp_b.last_of_run, exp_b.stream_done, exp_b.checksum);
            $display("%0t:          actual   byte=%h last=%b done=%b sum=%h", $time,
                     got_b.out_byte, got_b.last_of_run, got_b.stream_done, got_b.checksum);
          end
        end
      end
      out_ch.ready <= !sink_stall_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_sample(op, smp);
    n_items++;
  endtask

  // Hold the input until every expected byte is out, then let the encoder idle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (byte_stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DELTA_LIMIT)
      enc_limit = data[LIMIT_W-1:0];
    else if (idx == REG_REFRESH_INTERVAL)
      enc_refresh = data;
    n_cfg++;
  endtask

  task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic [SAMPLE_W-1:0] refresh);
    logic [CFG_DATA_W-1:0] wd;
    wait_drained();
    // upper bits of the limit write are junk and must be dropped
    wd = CFG_DATA_W'($urandom);
    wd[LIMIT_W-1:0] = limit;
    write_reg(REG_DELTA_LIMIT, wd);
    write_reg(REG_REFRESH_INTERVAL, refresh);
  endtask

  // Mostly small steps from the last sample, with some full-range jumps
  function automatic logic [SAMPLE_W-1:0] next_sample();
    logic [SAMPLE_W-1:0] s;
    if ($urandom_range(99) < 70)
      s = SAMPLE_W'(enc_prev + $urandom_range(18) - 9);
    else
      s = SAMPLE_W'($urandom);
    return s;
  endfunction

  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 6)
        send_item(OP_FINISH, SAMPLE_W'($urandom));
      else
        send_item(OP_SAMPLE, next_sample());
    end
  endtask

  task automatic test_directed();
    // reset defaults: limit 7, refresh 16384
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'h0007);
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'hfff8);   // minus eight, escaped with a held nibble
    send_item(OP_SAMPLE, 16'hffff);
    send_item(OP_SAMPLE, 16'h0000);   // wraps to plus one
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_FINISH, 16'hffff);   // terminator with a held nibble
    send_item(OP_FINISH, 16'h0000);   // terminator on empty state
    send_item(OP_SAMPLE, 16'h8000);   // largest difference
    send_item(OP_SAMPLE, 16'h7ff9);
    send_item(OP_SAMPLE, 16'h7ff1);
    send_item(OP_SAMPLE, 16'h7ff8);
    send_item(OP_SAMPLE, 16'h7ff8);
    send_item(OP_SAMPLE, 16'ha5a5);
    send_item(OP_SAMPLE, 16'h5a5a);
    send_item(OP_FINISH, 16'h1234);
    set_config(3'd0, 16'd16384);      // only a zero difference fits
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'h0001);
    send_item(OP_SAMPLE, 16'h0001);
    send_item(OP_FINISH, 16'h0000);
  endtask

  task automatic test_config_sweep();
    set_config(3'd0, 16'd1);
    run_random(12);
    set_config(3'd5, 16'd0);          // every sample escaped
    run_random(12);
    set_config(3'd7, 16'd65535);
    run_random(8);
    wait_drained();                   // sender holds off until all bytes are out
    run_random(8);
    set_config(3'd3, 16'd2);
    run_random(12);
    set_config(3'd1, 16'd5);
    run_random(12);
    set_config(DELTA_LIMIT_RST, REFRESH_INTERVAL_RST);
    run_random(12);
  endtask

  task automatic test_spare_regs();
    wait_drained();
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    run_random(6);
  endtask

  task automatic test_no_idle();
    set_config(3'd7, 16'd4);
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    run_random(25);
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    errors        = 0;
    n_items       = 0;
    n_beats       = 0;
    n_escaped     = 0;
    n_finish      = 0;
    n_cfg         = 0;
    enc_limit     = DELTA_LIMIT_RST;
    enc_refresh   = REFRESH_INTERVAL_RST;
    clear_encoder_state();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_SAMPLE;
    in_ch.sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_spare_regs();
    test_no_idle();
    wait_drained();

    $display("Sent %0d items (%0d escaped samples, %0d finishes), checked %0d bytes,",
             n_items, n_escaped, n_finish, n_beats);
    $display("over %0d register writes across limit/refresh extremes; %0d errors.",
             n_cfg, errors);
    if (errors == 0)
      $display("PASS nibble_delta_sample_encoder_top");
    else
      $display("FAIL nibble_delta_sample_encoder_top");
    $finish;
  end

endmodule
